// ----- hdl/tppi_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tppi_pkg
// Shared constants and types for the tile pixel palette indexer.
// ----------------------------------------------------------------------------
package tppi_pkg;

  // Tile and search geometry
  localparam int MAX_COLORS     = 4;
  localparam int TILE_PIXELS    = 64;
  localparam int SEARCH_COLUMNS = 14;
  localparam int SEARCH_ROWS    = 4;

  // Palette store
  localparam int ROW_W  = 2;
  localparam int COL_W  = 4;
  localparam int PAL_AW = ROW_W + COL_W;
  localparam int COLOR_W = 32;

  // Field widths
  localparam int DIST_W   = 18;
  localparam int CIDX_W   = 2;
  localparam int STATUS_W = 2;
  localparam int NCOL_W   = 3;

  // Derived widths
  localparam int LIDX_W = $clog2(MAX_COLORS);
  localparam int CNT_W  = $clog2(MAX_COLORS + 1);
  localparam int POS_W  = $clog2(TILE_PIXELS);
  localparam int LC_AW  = (MAX_COLORS > 2) ? $clog2(MAX_COLORS - 1) : 1;

  localparam logic [COLOR_W-1:0] BLACK_OPAQUE = 32'h0000_00FF;
  localparam logic [DIST_W-1:0]  DIST_START   =
    DIST_W'(255 * 255 + 255 * 255 + 255 * 255 + 255 * 255);
  localparam logic [ROW_W-1:0]   ROW_LAST     = ROW_W'(SEARCH_ROWS - 1);
  localparam logic [COL_W-1:0]   COL_LAST     = COL_W'(SEARCH_COLUMNS - 1);
  localparam logic [POS_W-1:0]   POS_LAST     = POS_W'(TILE_PIXELS - 1);

  // Opcodes carried on tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNMATCHED = 2'd2;

  // Palette position travelling with a distance calculation
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } search_tag_t;

endpackage
`default_nettype wire

// ----- hdl/tppi_palette_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tppi_palette_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tppi_palette_ram #(
  parameter int AW = 6,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tppi_dist_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tppi_dist_unit
// Squared RGBA distance: per-channel squares registered, summed at output.
// ----------------------------------------------------------------------------
module tppi_dist_unit
  import tppi_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire search_tag_t        in_tag,
  input  wire logic [COLOR_W-1:0] a,
  input  wire logic [COLOR_W-1:0] b,
  output logic                    out_valid,
  output search_tag_t             out_tag,
  output logic      [DIST_W-1:0]  out_dist
);

  logic [15:0] sq_d [4];
  logic [15:0] sq   [4];

  always_comb begin
    logic [7:0] ca;
    logic [7:0] cb;
    logic [7:0] diff;
    for (int ch = 0; ch < 4; ch++) begin
      ca   = a[8*ch +: 8];
      cb   = b[8*ch +: 8];
      diff = (ca > cb) ? (ca - cb) : (cb - ca);
      sq_d[ch] = 16'(diff) * 16'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_tag <= in_tag;
    for (int ch = 0; ch < 4; ch++) begin
      sq[ch] <= sq_d[ch];
    end
  end

  assign out_dist = DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]) + DIST_W'(sq[3]);

endmodule
`default_nettype wire

// ----- hdl/tile_pixel_palette_indexer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tile_pixel_palette_indexer_unit
// Gives each tile pixel a local colour index, matching new colours against
// the palette store by squared RGBA distance.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Content
//  s_axis   in         tuser opcode; tdata entry_index, colour
//  m_axis   out        tdata result fields; tlast on last pixel of tile
//  cfg      in         match threshold write (cfg_we / cfg_wdata)
//
// Palette writes and pixels of known colours complete as they are accepted.
// A new colour walks 56 palette entries, one RAM read per cycle; the unit then
// waits in the drain state until the RAM read register and the distance
// pipeline are empty, and holds off further input until its result is loaded.
// Reset (rst, synchronous) empties the tile state; the palette RAM is not
// cleared and must be written before it is searched.
// s_axis_tready drops while a search runs or a result waits in the output
// register.
// ----------------------------------------------------------------------------
module tile_pixel_palette_indexer_unit
  import tppi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // input stream
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [39:0]       s_axis_tdata,  // entry_index[5:0], color[37:6]
  input  wire logic              s_axis_tuser,  // opcode
  // result stream
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [39:0]       m_axis_tdata,  // color_index[1:0],
                                                // is_new_color[2],
                                                // palette_row[4:3],
                                                // palette_column[8:5],
                                                // distance[26:9], status[28:27],
                                                // colors_in_tile[31:29],
                                                // tile_matched[32]
  output logic                   m_axis_tlast,  // last_pixel
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [DIST_W-1:0] cfg_wdata      // match_threshold
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;

  logic [1:0]         state;
  logic [DIST_W-1:0]  threshold;

  // input unpack
  logic [PAL_AW-1:0]  in_entry;
  logic [COLOR_W-1:0] in_color;
  assign in_entry = s_axis_tdata[PAL_AW-1:0];
  assign in_color = s_axis_tdata[PAL_AW +: COLOR_W];

  // tile state
  logic [CNT_W-1:0]   count;
  logic [POS_W-1:0]   pos;
  logic               overflow;
  logic               unmatched;
  logic [COLOR_W-1:0] lc [MAX_COLORS-1];   // local colours 1 .. MAX_COLORS-1

  // search state
  logic [COLOR_W-1:0] pix_color;
  logic [ROW_W-1:0]   rd_row;
  logic [COL_W-1:0]   rd_col;
  logic               p1_valid;
  search_tag_t        p1_tag;
  logic [COLOR_W-1:0] pal_rdata;
  logic               p2_valid;
  search_tag_t        p2_tag;
  logic [DIST_W-1:0]  p2_dist;
  logic [DIST_W-1:0]  best;
  logic [ROW_W-1:0]   best_row;
  logic [COL_W-1:0]   best_col;

  // output register
  logic [CIDX_W-1:0]   o_idx;
  logic                o_new;
  logic [ROW_W-1:0]    o_row;
  logic [COL_W-1:0]    o_col;
  logic [DIST_W-1:0]   o_dist;
  logic [STATUS_W-1:0] o_status;
  logic [NCOL_W-1:0]   o_ncol;
  logic                o_matched;

  logic in_acc;
  logic out_free;
  logic search_done;
  logic match_ok;
  logic tile_end;
  logic start_search;
  logic out_load;

  // Known-colour lookup; lowest matching index wins, black is index 0.
  logic              hit;
  logic [LIDX_W-1:0] hit_idx;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign search_done   = (state == ST_DRAIN) && !p1_valid && !p2_valid && out_free;
  assign match_ok      = best < threshold;
  assign tile_end      = (pos == POS_LAST);
  // new colour with room left and no sticky overflow
  assign start_search  = !overflow && !hit && (count < CNT_W'(MAX_COLORS));
  // a result enters the output register this cycle
  assign out_load      = (in_acc && (s_axis_tuser == OP_PIXEL) && !start_search) ||
                         search_done;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = MAX_COLORS - 1; k >= 1; k--) begin
      if ((CNT_W'(k) < count) && (lc[k-1] == in_color)) begin
        hit     = 1'b1;
        hit_idx = LIDX_W'(k);
      end
    end
    if (in_color == BLACK_OPAQUE) begin
      hit     = 1'b1;
      hit_idx = '0;
    end
  end

  // Palette store
  tppi_palette_ram #(
    .AW (PAL_AW),
    .DW (COLOR_W)
  ) u_palette (
    .clk   (clk),
    .we    (in_acc && (s_axis_tuser == OP_WRITE)),
    .waddr (in_entry),
    .wdata (in_color),
    .re    (state == ST_SEARCH),
    .raddr ({rd_row, rd_col}),
    .rdata (pal_rdata)
  );

  // Distance pipeline
  tppi_dist_unit u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p1_valid),
    .in_tag    (p1_tag),
    .a         (pal_rdata),
    .b         (pix_color),
    .out_valid (p2_valid),
    .out_tag   (p2_tag),
    .out_dist  (p2_dist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      threshold     <= '0;
      count         <= CNT_W'(1);
      pos           <= '0;
      overflow      <= 1'b0;
      unmatched     <= 1'b0;
      p1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      p1_valid <= (state == ST_SEARCH);
      p1_tag   <= '{row: rd_row, col: rd_col};

      // hold until taken, reload when a new result is ready
      m_axis_tvalid <= out_load || (m_axis_tvalid && !m_axis_tready);

      // running minimum, first strict minimum kept
      if (p2_valid && (p2_dist < best)) begin
        best     <= p2_dist;
        best_row <= p2_tag.row;
        best_col <= p2_tag.col;
      end

      case (state)
        ST_IDLE: begin
          if (in_acc && (s_axis_tuser == OP_PIXEL)) begin
            pix_color <= in_color;
            if (start_search) begin
              // new colour with room left: search the palette
              state    <= ST_SEARCH;
              rd_row   <= '0;
              rd_col   <= '0;
              best     <= DIST_START;
              best_row <= '0;
              best_col <= '0;
            end else begin
              // known colour, or overflow (sticky or fresh)
              o_idx         <= hit ? CIDX_W'(hit_idx) : '0;
              o_new         <= 1'b0;
              o_row         <= '0;
              o_col         <= '0;
              o_dist        <= '0;
              o_status      <= (overflow || !hit) ? STATUS_OVERFLOW : STATUS_OK;
              o_ncol        <= NCOL_W'(count);
              o_matched     <= !unmatched;
              m_axis_tlast  <= tile_end;
              if (tile_end) begin
                pos       <= '0;
                count     <= CNT_W'(1);
                overflow  <= 1'b0;
                unmatched <= 1'b0;
              end else begin
                pos <= pos + POS_W'(1);
                if (!hit) begin
                  overflow <= 1'b1;
                end
              end
            end
          end
        end

        ST_SEARCH: begin
          if (rd_col == COL_LAST) begin
            rd_col <= '0;
            rd_row <= rd_row + ROW_W'(1);
            if (rd_row == ROW_LAST) begin
              state <= ST_DRAIN;
            end
          end else begin
            rd_col <= rd_col + COL_W'(1);
          end
        end

        ST_DRAIN: begin
          if (search_done) begin
            state                   <= ST_IDLE;
            lc[LC_AW'(count - 1'b1)] <= pix_color;
            o_idx         <= CIDX_W'(count);
            o_new         <= 1'b1;
            o_row         <= best_row;
            o_col         <= best_col;
            o_dist        <= best;
            o_status      <= match_ok ? STATUS_OK : STATUS_UNMATCHED;
            o_ncol        <= NCOL_W'(count + CNT_W'(1));
            o_matched     <= match_ok && !unmatched;
            m_axis_tlast  <= tile_end;
            if (tile_end) begin
              pos       <= '0;
              count     <= CNT_W'(1);
              overflow  <= 1'b0;
              unmatched <= 1'b0;
            end else begin
              pos   <= pos + POS_W'(1);
              count <= count + CNT_W'(1);
              if (!match_ok) begin
                unmatched <= 1'b1;
              end
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = {7'd0, o_matched, o_ncol, o_status, o_dist, o_col, o_row,
                         o_new, o_idx};

`ifndef SYNTHESIS
  // overflow can only be raised with a full colour table
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow |-> (count == CNT_W'(MAX_COLORS)))
    else $error("overflow set with free colour slots");

  // distance results only arrive during a search
  a_dist_in_search: assert property (@(posedge clk) disable iff (rst)
    p2_valid |-> ((state == ST_SEARCH) || (state == ST_DRAIN)))
    else $error("distance result outside search");

  // a finished search adds exactly one local colour
  a_search_adds: assert property (@(posedge clk) disable iff (rst)
    (search_done && !tile_end) |=> (count == $past(count) + CNT_W'(1)))
    else $error("search did not add a colour");

  // searches start from the first palette entry
  a_search_start: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SEARCH) && ($past(state) == ST_IDLE)) |->
      ((rd_row == '0) && (rd_col == '0) && (best == DIST_START)))
    else $error("search started mid palette");
`endif

endmodule
`default_nettype wire
